[rtl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure compensation pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

	localparam int PIPE_DEPTH = 11;
	localparam int CAL_IDX_W  = 3;

	typedef enum logic [CAL_IDX_W-1:0] {
		CAL_C1 = 3'd0,
		CAL_C2 = 3'd1,
		CAL_C3 = 3'd2,
		CAL_C4 = 3'd3,
		CAL_C5 = 3'd4,
		CAL_C6 = 3'd5
	} cal_idx_t;

	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
	} cal_t;

	// first-order terms, t = TEMP - 2000, u = TEMP + 1500
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [18:0] t;
		logic signed [18:0] u;
		logic               cold;
		logic               very_cold;
		logic signed [41:0] off;
		logic signed [41:0] sens;
	} first_t;

	// corrected offset and sensitivity
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [41:0] off2;
		logic signed [41:0] sens2;
	} second_t;

endpackage

[rtl/psc_cfg.sv]
// ----------------------------------------------------------------------------
// psc_cfg
// Calibration word registers, written through the configuration port.
// ----------------------------------------------------------------------------
module psc_cfg
	import psc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CAL_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output cal_t                 cal
);

	cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_write) begin
			unique case (cal_idx_t'(cfg_index))
				CAL_C1: cal_q.c1 <= cfg_data;
				CAL_C2: cal_q.c2 <= cfg_data;
				CAL_C3: cal_q.c3 <= cfg_data;
				CAL_C4: cal_q.c4 <= cfg_data;
				CAL_C5: cal_q.c5 <= cfg_data;
				CAL_C6: cal_q.c6 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cal = cal_q;

endmodule

[rtl/psc_ctl.sv]
// ----------------------------------------------------------------------------
// psc_ctl
// Valid bits of the pipeline and per-stage advance enables; a stage moves
// when it is empty or when the stage after it can move.
// ----------------------------------------------------------------------------
module psc_ctl
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIPE_DEPTH-1:0] adv
);

	logic [PIPE_DEPTH-1:0] valid_q;

	always_comb begin
		logic [PIPE_DEPTH-1:0] lowm;
		for (int i = 0; i < PIPE_DEPTH; i++) begin
			lowm   = PIPE_DEPTH'((64'd1 << i) - 64'd1);
			adv[i] = !out_stall || !(&(valid_q | lowm));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) valid_q[0] <= in_valid;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				if (adv[i]) valid_q[i] <= valid_q[i-1];
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = valid_q[PIPE_DEPTH-1];

endmodule

[rtl/psc_first.sv]
// ----------------------------------------------------------------------------
// psc_first
// Stages 1-3: dT, the three calibration products, TEMP, OFF and SENS.
// ----------------------------------------------------------------------------
module psc_first
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic [PIPE_DEPTH-1:0] adv,
	input  cal_t                  cal,
	input  logic [23:0]           raw_pressure,
	input  logic [23:0]           raw_temperature,
	output first_t                first
);

	logic [23:0]        d1_s1, d1_s2;
	logic signed [24:0] dt_s1;
	logic signed [41:0] p6_s2, p4_s2, p3_s2;
	first_t             first_s3;

	logic signed [41:0] p6_b, p4_b, p3_b;
	logic signed [18:0] q;

	always_comb begin
		p6_b = p6_s2 + (p6_s2[41] ? 42'sd8388607 : 42'sd0);
		p4_b = p4_s2 + (p4_s2[41] ? 42'sd127 : 42'sd0);
		p3_b = p3_s2 + (p3_s2[41] ? 42'sd255 : 42'sd0);
		q    = p6_b[41:23];
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});
		end
		if (adv[1]) begin
			d1_s2 <= d1_s1;
			p6_s2 <= dt_s1 * $signed({1'b0, cal.c6});
			p4_s2 <= dt_s1 * $signed({1'b0, cal.c4});
			p3_s2 <= dt_s1 * $signed({1'b0, cal.c3});
		end
		if (adv[2]) begin
			first_s3.d1        <= d1_s2;
			first_s3.t         <= q;
			first_s3.u         <= q + 19'sd3500;
			first_s3.cold      <= q[18];
			first_s3.very_cold <= q <= -19'sd3600;
			first_s3.off       <= $signed({10'd0, cal.c2, 16'd0})
				+ $signed({{7{p4_b[41]}}, p4_b[41:7]});
			first_s3.sens      <= $signed({11'd0, cal.c1, 15'd0})
				+ $signed({{8{p3_b[41]}}, p3_b[41:8]});
		end
	end

	assign first = first_s3;

endmodule

[rtl/psc_second.sv]
// ----------------------------------------------------------------------------
// psc_second
// Stages 4-6: squares, second-order correction terms, OFF2 and SENS2.
// ----------------------------------------------------------------------------
module psc_second
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic [PIPE_DEPTH-1:0] adv,
	input  first_t                first,
	output second_t               second
);

	logic [23:0]        d1_s4, d1_s5;
	logic signed [41:0] off_s4, sens_s4, off_s5, sens_s5;
	logic               cold_s4, very_s4;
	logic [35:0]        sq1_s4, sq2_s4;
	logic [39:0]        offi_s5, sensi_s5;
	second_t            second_s6;

	logic signed [37:0] sq1_full, sq2_full;
	logic [39:0]        sq1_x3, sq1_x5, sq2_x7, sq2_x4, offi, sensi;

	always_comb begin
		sq1_full = first.t * first.t;
		sq2_full = first.u * first.u;
		sq1_x3   = {4'd0, sq1_s4} + {3'd0, sq1_s4, 1'b0};
		sq1_x5   = {4'd0, sq1_s4} + {2'd0, sq1_s4, 2'b0};
		sq2_x7   = {1'b0, sq2_s4, 3'b0} - {4'd0, sq2_s4};
		sq2_x4   = {2'd0, sq2_s4, 2'b0};
		if (cold_s4) begin
			offi  = (sq1_x3 >> 1) + (very_s4 ? sq2_x7 : 40'd0);
			sensi = (sq1_x5 >> 3) + (very_s4 ? sq2_x4 : 40'd0);
		end else begin
			offi  = {4'd0, sq1_s4} >> 4;
			sensi = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			d1_s4   <= first.d1;
			off_s4  <= first.off;
			sens_s4 <= first.sens;
			cold_s4 <= first.cold;
			very_s4 <= first.very_cold;
			sq1_s4  <= sq1_full[35:0];
			sq2_s4  <= sq2_full[35:0];
		end
		if (adv[4]) begin
			d1_s5    <= d1_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			offi_s5  <= offi;
			sensi_s5 <= sensi;
		end
		if (adv[5]) begin
			second_s6.d1    <= d1_s5;
			second_s6.off2  <= off_s5 - $signed({2'd0, offi_s5});
			second_s6.sens2 <= sens_s5 - $signed({2'd0, sensi_s5});
		end
	end

	assign second = second_s6;

endmodule

[rtl/psc_final.sv]
// ----------------------------------------------------------------------------
// psc_final
// Stages 7-11: D1*SENS2 as two partial products, scaling and OFF2 removal.
// ----------------------------------------------------------------------------
module psc_final
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic [PIPE_DEPTH-1:0] adv,
	input  second_t               second,
	output logic signed [31:0]    pressure_out
);

	logic signed [45:0] hi_s7;
	logic [44:0]        lo_s7;
	logic signed [41:0] off2_s7, off2_s8, off2_s9;
	logic signed [66:0] prod_s8;
	logic signed [45:0] q_s9;
	logic signed [46:0] x_s10;
	logic signed [31:0] p_s11;

	logic signed [66:0] prod_b;
	logic signed [46:0] x_b;

	always_comb begin
		prod_b = prod_s8 + (prod_s8[66] ? 67'sd2097151 : 67'sd0);
		x_b    = x_s10 + (x_s10[46] ? 47'sd8191 : 47'sd0);
	end

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			hi_s7   <= $signed({1'b0, second.d1}) * $signed(second.sens2[41:21]);
			lo_s7   <= {21'd0, second.d1} * {24'd0, second.sens2[20:0]};
			off2_s7 <= second.off2;
		end
		if (adv[7]) begin
			prod_s8 <= $signed({hi_s7, 21'd0}) + $signed({22'd0, lo_s7});
			off2_s8 <= off2_s7;
		end
		if (adv[8]) begin
			q_s9    <= prod_b[66:21];
			off2_s9 <= off2_s8;
		end
		if (adv[9]) begin
			x_s10 <= $signed({q_s9[45], q_s9})
				- $signed({{5{off2_s9[41]}}, off2_s9});
		end
		if (adv[10]) begin
			p_s11 <= x_b[44:13];
		end
	end

	assign pressure_out = p_s11;

endmodule

[rtl/pressure_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// pressure_sensor_compensation_unit
// Second-order compensated pressure from raw D1/D2 conversions and six
// calibration words.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    raw_pressure, raw_temperature
//   out       out_valid / out_stall  pressure_out
//   cfg       cfg_write              cfg_index, cfg_data
//
// Eleven register stages; one item per cycle while the output does not
// stall. Depth is set by the 64-bit D1*SENS2 product, split into two
// partial products. Reset clears the valid bits and the calibration words.
// An empty stage fills even while the output stalls, so bubbles collapse.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation_unit
	import psc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [23:0]           raw_pressure,
	input  logic [23:0]           raw_temperature,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    pressure_out,
	input  logic                  cfg_write,
	input  logic [CAL_IDX_W-1:0]  cfg_index,
	input  logic [15:0]           cfg_data
);

	cal_t                  cal;
	logic [PIPE_DEPTH-1:0] adv;
	first_t                first;
	second_t               second;

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	psc_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.adv       (adv)
	);

	psc_first u_first (
		.clk             (clk),
		.adv             (adv),
		.cal             (cal),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.first           (first)
	);

	psc_second u_second (
		.clk    (clk),
		.adv    (adv),
		.first  (first),
		.second (second)
	);

	psc_final u_final (
		.clk          (clk),
		.adv          (adv),
		.second       (second),
		.pressure_out (pressure_out)
	);

endmodule

[tb/tb_pressure_sensor_compensation_unit.sv]
// ----------------------------------------------------------------------------
// tb_pressure_sensor_compensation_unit
// Self-checking bench for the second-order pressure compensation pipeline.
//
// Raw D1/D2 pairs are queued by the stimulus process and offered by a clocked
// driver with random gaps. Each accepted pair is run through a 64-bit
// predictor of the compensation math, and the resulting pressure is checked
// in order against the output channel. The receiver stalls at random and
// once holds off long enough to back the pipeline up. Calibration words are
// rewritten between phases while the pipeline is empty. Settings include
// reset values, all-ones, datasheet-like values and random values.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_compensation_unit
	import psc_pkg::*;
;

	localparam int RX_HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
	localparam logic [23:0] D2_MID = 24'h800000;
	localparam logic [CAL_IDX_W-1:0] CAL_SPARE_LO = 3'd6;
	localparam logic [CAL_IDX_W-1:0] CAL_SPARE_HI = 3'd7;

	typedef struct {
		logic [23:0] d1;
		logic [23:0] d2;
	} raw_pair_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [23:0]          raw_pressure = '0;
	logic [23:0]          raw_temperature = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [31:0]   pressure_out;
	logic                 cfg_write = 1'b0;
	logic [CAL_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	cal_t               cal_shadow = '0;
	raw_pair_t          raw_pairs[$];
	logic signed [31:0] expected_pressure[$];

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit tx_pause = 1'b0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold_reqs = 0;
	int rx_hold_done = 0;

	int n_errors = 0;
	int n_accepted = 0;
	int n_results = 0;
	int n_cold = 0;
	int n_very_cold = 0;
	int n_backpressure = 0;
	int n_settings = 0;
	int n_cycles = 0;

	pressure_sensor_compensation_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressure_out    (pressure_out),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// 64-bit signed math, divisions truncate toward zero
	function automatic logic signed [31:0] compensate_pressure(input logic [23:0] d1_raw,
			input logic [23:0] d2_raw, output bit cold, output bit very_cold);
		longint c1, c2, c3, c4, c5, c6;
		longint d1, d2, dt, temp_c, off, sens, offi, sensi, t2, u2, p;
		c1 = cal_shadow.c1;
		c2 = cal_shadow.c2;
		c3 = cal_shadow.c3;
		c4 = cal_shadow.c4;
		c5 = cal_shadow.c5;
		c6 = cal_shadow.c6;
		d1 = d1_raw;
		d2 = d2_raw;
		dt = d2 - c5 * 256;
		temp_c = 2000 + (dt * c6) / 8388608;
		off = c2 * 65536 + (c4 * dt) / 128;
		sens = c1 * 32768 + (c3 * dt) / 256;
		t2 = (temp_c - 2000) * (temp_c - 2000);
		u2 = (temp_c + 1500) * (temp_c + 1500);
		cold = (temp_c / 100) < 20;
		very_cold = cold && ((temp_c / 100) < -15);
		if (cold) begin
			offi = (3 * t2) / 2;
			sensi = (5 * t2) / 8;
			if (very_cold) begin
				offi += 7 * u2;
				sensi += 4 * u2;
			end
		end else begin
			offi = t2 / 16;
			sensi = 0;
		end
		p = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
		return p[31:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] d2_for_temp(input int temp_c);
		// valid while c5 = c6 = 32768: TEMP = 2000 + dT/256
		return 24'(8388608 + (temp_c - 2000) * 256);
	endfunction

	function automatic raw_pair_t random_pair();
		raw_pair_t rp;
		int span;
		int ofs;
		int d2_val;
		rp.d1 = 24'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			rp.d2 = 24'($urandom);
		end else begin
			// near the reference temperature, where the branches change
			span = 1 << $urandom_range(4, 22);
			ofs = $urandom_range(0, 2 * span);
			d2_val = int'(cal_shadow.c5) * 256 + ofs - span;
			if (d2_val < 0)
				d2_val = 0;
			if (d2_val > int'(RAW_MAX))
				d2_val = int'(RAW_MAX);
			rp.d2 = 24'(d2_val);
		end
		return rp;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		n_errors++;
		$display("mismatch on %s: expected %h, got %h (result %0d)", what, want, got,
			n_results);
	endtask

	task automatic write_cal(input logic [CAL_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CAL_C1: cal_shadow.c1 = val;
			CAL_C2: cal_shadow.c2 = val;
			CAL_C3: cal_shadow.c3 = val;
			CAL_C4: cal_shadow.c4 = val;
			CAL_C5: cal_shadow.c5 = val;
			CAL_C6: cal_shadow.c6 = val;
			default: ;
		endcase
	endtask

	task automatic load_cal(input logic [15:0] c1, input logic [15:0] c2,
			input logic [15:0] c3, input logic [15:0] c4, input logic [15:0] c5,
			input logic [15:0] c6);
		write_cal(CAL_C1, c1);
		write_cal(CAL_C2, c2);
		write_cal(CAL_C3, c3);
		write_cal(CAL_C4, c4);
		write_cal(CAL_C5, c5);
		write_cal(CAL_C6, c6);
		n_settings++;
		@(negedge clk);
	endtask

	task automatic queue_random(input int count);
		repeat (count) raw_pairs.push_back(random_pair());
	endtask

	task automatic push_pair(input logic [23:0] d1, input logic [23:0] d2);
		raw_pair_t rp;
		rp.d1 = d1;
		rp.d2 = d2;
		raw_pairs.push_back(rp);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (raw_pairs.size() != 0 || in_valid || expected_pressure.size() != 0);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_raw
		raw_pair_t rp;
		logic signed [31:0] want;
		bit cold;
		bit very_cold;
		logic next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			raw_pressure <= '0;
			raw_temperature <= '0;
			tx_gap = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && in_stall)
				n_backpressure++;
			if (in_valid && !in_stall) begin
				want = compensate_pressure(raw_pressure, raw_temperature, cold, very_cold);
				expected_pressure.push_back(want);
				n_accepted++;
				n_cold += cold;
				n_very_cold += very_cold;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (!tx_pause && raw_pairs.size() != 0) begin
					rp = raw_pairs.pop_front();
					raw_pressure <= rp.d1;
					raw_temperature <= rp.d2;
					next_valid = 1'b1;
					tx_gap = tx_quiet ? 0 : pick_gap();
				end
			end
			in_valid <= next_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_pressure
		logic signed [31:0] want;
		logic next_stall;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_pressure.size() == 0) begin
					report_mismatch("unexpected result", 'x, pressure_out);
				end else begin
					want = expected_pressure.pop_front();
					if (pressure_out !== want)
						report_mismatch("pressure_out", want, pressure_out);
				end
			end
			if (rx_hold_done != rx_hold_reqs) begin
				rx_hold_done++;
				rx_gap = RX_HOLD_CYCLES;
			end
			if (rx_gap == 0 && !rx_quiet && $urandom_range(0, 3) == 0)
				rx_gap = pick_gap();
			next_stall = rx_gap > 0;
			if (rx_gap > 0)
				rx_gap--;
			out_stall <= next_stall;
		end
	end

	initial begin : stimulus
		int base;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// calibration still at reset
		queue_random(30);
		drain();

		// c5 = c6 = 32768 makes TEMP directly steerable through D2
		load_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd32768, 16'd32768);
		push_pair('0, D2_MID);
		push_pair(RAW_MAX, D2_MID);
		push_pair(24'($urandom), D2_MID - 24'd1);
		push_pair(24'($urandom), D2_MID - 24'd255);
		push_pair(24'($urandom), D2_MID - 24'd256);
		push_pair(RAW_MAX, d2_for_temp(1999));
		push_pair(24'($urandom), d2_for_temp(1900));
		push_pair(24'($urandom), d2_for_temp(2099));
		push_pair(24'($urandom), d2_for_temp(2100));
		push_pair(24'($urandom), d2_for_temp(99));
		push_pair(24'($urandom), d2_for_temp(-99));
		push_pair(24'($urandom), d2_for_temp(-100));
		push_pair(24'($urandom), d2_for_temp(-1500));
		push_pair(24'($urandom), d2_for_temp(-1501));
		push_pair(24'($urandom), d2_for_temp(-1599));
		push_pair(RAW_MAX, d2_for_temp(-1600));
		push_pair(24'($urandom), d2_for_temp(-1601));
		push_pair(RAW_MAX, '0);
		push_pair('0, '0);
		push_pair(RAW_MAX, RAW_MAX);
		push_pair('0, RAW_MAX);
		drain();

		// datasheet-like words; receiver backs the pipeline up once
		load_cal(16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146);
		base = n_accepted;
		queue_random(250);
		while (n_accepted < base + 30)
			@(negedge clk);
		tx_quiet = 1'b1;
		rx_hold_reqs++;
		while (rx_hold_done != rx_hold_reqs || rx_gap != 0)
			@(negedge clk);
		tx_quiet = 1'b0;
		drain();

		// all ones, no idling on either side
		load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		queue_random(150);
		drain();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// random words; sender waits mid-phase until the pipeline is empty
		load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		base = n_accepted;
		queue_random(250);
		while (n_accepted < base + 100)
			@(negedge clk);
		tx_pause = 1'b1;
		while (in_valid || expected_pressure.size() != 0)
			@(negedge clk);
		tx_pause = 1'b0;
		drain();

		// deepest cold, writes to the unused indexes must be ignored
		load_cal('0, '0, '0, '0, 16'hFFFF, 16'hFFFF);
		write_cal(CAL_SPARE_LO, 16'($urandom));
		write_cal(CAL_SPARE_HI, 16'($urandom));
		@(negedge clk);
		queue_random(150);
		drain();

		load_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		queue_random(200);
		drain();

		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (expected_pressure.size() != 0)
			report_mismatch("missing result", expected_pressure[0], 'x);
		$display("checked %0d results from %0d items over %0d calibration sets",
			n_results, n_accepted, n_settings);
		$display("%0d cold, %0d very cold, %0d input cycles stalled by the pipeline",
			n_cold, n_very_cold, n_backpressure);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[pressure_sensor_compensation_unit.f]
rtl/psc_pkg.sv
rtl/psc_cfg.sv
rtl/psc_ctl.sv
rtl/psc_first.sv
rtl/psc_second.sv
rtl/psc_final.sv
rtl/pressure_sensor_compensation_unit.sv
tb/tb_pressure_sensor_compensation_unit.sv
